[hdl/fjpt_pkg.sv]
// ----------------------------------------------------------------------------
// fjpt_pkg: shared types and constants of the flat json property tokenizer
// request and response words, parse phases, character and code constants
// ----------------------------------------------------------------------------
package fjpt_pkg;

   // packet size limit and most properties per packet, fixed by the word layout
   localparam int MAX_PACKET_BYTES = 1024;
   localparam int PROPERTY_CAP     = 32;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } req_type;

   typedef struct packed {
      logic        record_kind;
      logic [9:0]  key_offset;
      logic [10:0] key_length;
      logic [10:0] value_offset;
      logic [10:0] value_length;
      logic [1:0]  value_kind;
      logic [4:0]  property_index;
      logic [5:0]  property_count;
      logic        packet_overflow;
      logic        run_last;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_LEAD    = 4'd0,
      PH_TOP     = 4'd1,
      PH_KEYSKIP = 4'd2,
      PH_KEY     = 4'd3,
      PH_COLON   = 4'd4,
      PH_VALSKIP = 4'd5,
      PH_STRVAL  = 4'd6,
      PH_BAREVAL = 4'd7,
      PH_SEP     = 4'd8,
      PH_DONE    = 4'd9
   } phase_type;

   localparam logic REC_PROPERTY = 1'b0;
   localparam logic REC_END      = 1'b1;

   localparam logic [1:0] VT_STRING  = 2'd0;
   localparam logic [1:0] VT_INTEGER = 2'd1;
   localparam logic [1:0] VT_DOUBLE  = 2'd2;
   localparam logic [1:0] VT_BOOLEAN = 2'd3;

   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_ONE    = 8'h31;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;

   localparam logic [5:0] LIMIT_RESET = 6'd32;

endpackage

[hdl/fjpt_fifo.sv]
// ----------------------------------------------------------------------------
// fjpt_fifo: result queue
// small register queue that takes up to two words per cycle and gives one
// ----------------------------------------------------------------------------
module fjpt_fifo #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push0,
   input  logic            push1,
   input  fjpt_pkg::rsp_type push_word0,
   input  fjpt_pkg::rsp_type push_word1,
   input  logic            pop,
   output logic            out_valid,
   output fjpt_pkg::rsp_type out_word,
   output logic            room2
);
   import fjpt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + PTR_W'(1);

   always_ff @(posedge clock) begin
      if (push0) mem_ff[wr_ptr_ff] <= push_word0;
      if (push1) mem_ff[wr_ptr_next] <= push_word1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push0) + PTR_W'(push1);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[rd_ptr_ff];
   assign room2     = (count_ff <= CNT_W'(DEPTH - 2));

endmodule

[hdl/flat_json_property_tokenizer_core.sv]
// ----------------------------------------------------------------------------
// flat_json_property_tokenizer_core: flat json object tokenizer
// walks packet bytes and reports key/value offsets, lengths and types
// ----------------------------------------------------------------------------
// The block takes one packet byte per cycle unless the input stalls. A byte is
// registered at the input, parsed in the following cycle by a single pass of
// phase logic (the phase chain of one byte resolves combinationally), and its
// records go into a four-entry result queue; the first result word of a byte
// is valid at the output from the next clock edge on. A byte causes at most
// two records (a property and the end record), and the queue hands its words
// out one at a time, so the output side sets the rate only while it is stalled
// or while end-of-packet bytes that also close a property come back to back.
// The input stalls while its register holds a byte and the queue has fewer
// than two free slots. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module flat_json_property_tokenizer_core (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  fjpt_pkg::req_type req_word,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fjpt_pkg::rsp_type rsp_word,
   // property limit register
   input  logic              csr_write_enable,
   input  logic [5:0]        csr_write_data
);
   import fjpt_pkg::*;

   // positions saturate at MAX_PACKET_BYTES, key offsets at one below it
   localparam int POS_W  = $clog2(MAX_PACKET_BYTES + 1);
   localparam int KOFF_W = $clog2(MAX_PACKET_BYTES);
   localparam int CNT_W  = $clog2(PROPERTY_CAP + 1);
   localparam int LIM_W  = (CNT_W > 6) ? CNT_W : 6;
   localparam int QDEPTH = 4;

   localparam logic [POS_W-1:0]  POS_MAX  = POS_W'(MAX_PACKET_BYTES);
   localparam logic [KOFF_W-1:0] KOFF_MAX = KOFF_W'(MAX_PACKET_BYTES - 1);
   localparam logic [LIM_W-1:0]  LIM_MAX  = LIM_W'(PROPERTY_CAP);

   // input register
   logic    in_vld_ff, in_vld_in;
   req_type in_word_ff;
   logic    proc;
   logic    q_room2;

   // packet state
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [KOFF_W-1:0]  key_begin_ff, key_begin_in;
   logic [POS_W-1:0]   key_size_ff, key_size_in;
   logic [POS_W-1:0]   value_begin_ff, value_begin_in;
   logic               dot_ff, dot_in;
   logic [7:0]         first_char_ff, first_char_in;
   logic [CNT_W-1:0]   found_ff, found_in;
   logic               overflow_ff, overflow_in;
   logic [5:0]         limit_ff;

   // parse results of the byte in the input register
   logic [7:0]         b;
   logic               eop;
   logic [POS_W-1:0]   cur, nxt;
   logic [LIM_W-1:0]   limit_eff;
   logic               ovf_now;
   phase_type          ph;
   logic [KOFF_W-1:0]  kb;
   logic [POS_W-1:0]   ks, vb;
   logic               dot;
   logic [7:0]         fc;
   logic               go_top, go_bare;
   logic               emit, emit_bare;
   logic [POS_W-1:0]   emit_end;
   logic [CNT_W-1:0]   found_after;
   logic [POS_W-1:0]   val_len;
   logic [1:0]         val_type;
   rsp_type            prop_rec, end_rec;
   rsp_type            push_word0, push_word1;
   logic               push0, push1;
   logic               rsp_take;

   // ---------------------------------------------------------------------
   // input register: holds a byte until the queue can take its records
   // ---------------------------------------------------------------------
   assign proc      = in_vld_ff && q_room2;
   assign req_stall = in_vld_ff && !q_room2;
   assign in_vld_in = req_stall ? in_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
   end

   // property limit register, kept across packets
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         limit_ff <= csr_write_data;
      end
   end

   // ---------------------------------------------------------------------
   // parse pass: one byte walks its whole phase chain here
   // ---------------------------------------------------------------------
   always_comb begin
      b   = in_word_ff.data_byte;
      eop = in_word_ff.end_of_packet;

      // saturated positions of this byte and the next
      ovf_now = overflow_ff || (pos_ff >= POS_MAX);
      cur     = (pos_ff >= POS_MAX) ? POS_MAX : pos_ff;
      nxt     = (cur < POS_MAX) ? cur + POS_W'(1) : POS_MAX;

      limit_eff = (LIM_W'(limit_ff) > LIM_MAX) ? LIM_MAX : LIM_W'(limit_ff);

      ph        = phase_ff;
      kb        = key_begin_ff;
      ks        = key_size_ff;
      vb        = value_begin_ff;
      dot       = dot_ff;
      fc        = first_char_ff;
      go_top    = 1'b0;
      go_bare   = 1'b0;
      emit      = 1'b0;
      emit_bare = 1'b0;
      emit_end  = cur;

      unique case (phase_ff)
         PH_LEAD: begin
            if (b != CH_SPACE && b != CH_LBRACE) go_top = 1'b1;
         end
         PH_TOP: begin
            go_top = 1'b1;
         end
         PH_KEYSKIP: begin
            if (b != CH_SPACE && b != CH_QUOTE) begin
               kb = (cur < POS_MAX) ? KOFF_W'(cur) : KOFF_MAX;
               ph = PH_KEY;
            end
         end
         PH_KEY: begin
            if (b == CH_QUOTE) begin
               ks = cur - POS_W'(key_begin_ff);
               ph = PH_COLON;
            end
         end
         PH_COLON: begin
            if (b == CH_COLON) ph = PH_VALSKIP;
         end
         PH_VALSKIP: begin
            if (b == CH_QUOTE) begin
               vb = nxt;
               ph = PH_STRVAL;
            end else if (b != CH_SPACE) begin
               // bare value starts on this very byte
               vb      = cur;
               dot     = 1'b0;
               fc      = b;
               go_bare = 1'b1;
            end
         end
         PH_STRVAL: begin
            if (b == CH_QUOTE) begin
               emit = 1'b1;
               ph   = PH_SEP;
            end
         end
         PH_BAREVAL: begin
            go_bare = 1'b1;
         end
         PH_SEP: begin
            if (b != CH_COMMA && b != CH_SPACE) go_top = 1'b1;
         end
         default: begin
            ph = PH_DONE;
         end
      endcase

      // bare value body: a comma or closing brace ends it
      if (go_bare) begin
         if (b == CH_COMMA || b == CH_RBRACE) begin
            emit      = 1'b1;
            emit_bare = 1'b1;
            ph        = PH_SEP;
            if (b == CH_RBRACE) go_top = 1'b1;
         end else begin
            ph = PH_BAREVAL;
            if (b == CH_DOT) dot = 1'b1;
         end
      end

      found_after = found_ff + CNT_W'(emit);

      // start of a property, or the end of parsing
      if (go_top) begin
         if (b == CH_RBRACE || LIM_W'(found_after) >= limit_eff) begin
            ph = PH_DONE;
         end else if (b != CH_SPACE && b != CH_QUOTE) begin
            kb = (cur < POS_MAX) ? KOFF_W'(cur) : KOFF_MAX;
            ph = PH_KEY;
         end else begin
            ph = PH_KEYSKIP;
         end
      end

      // packet ends inside a value: that value runs to the end
      if (eop && !emit && (ph == PH_STRVAL || ph == PH_BAREVAL)) begin
         emit      = 1'b1;
         emit_bare = (ph == PH_BAREVAL);
         emit_end  = nxt;
      end

      found_after = found_ff + CNT_W'(emit);

      val_len = (emit_end >= vb) ? emit_end - vb : '0;
      if (!emit_bare) begin
         val_type = VT_STRING;
      end else if (val_len == POS_W'(1) && (fc == CH_ZERO || fc == CH_ONE)) begin
         val_type = VT_BOOLEAN;
      end else if (dot) begin
         val_type = VT_DOUBLE;
      end else begin
         val_type = VT_INTEGER;
      end

      prop_rec.record_kind     = REC_PROPERTY;
      prop_rec.key_offset      = 10'(kb);
      prop_rec.key_length      = 11'(ks);
      prop_rec.value_offset    = 11'(vb);
      prop_rec.value_length    = 11'(val_len);
      prop_rec.value_kind      = val_type;
      prop_rec.property_index  = 5'(found_ff);
      prop_rec.property_count  = '0;
      prop_rec.packet_overflow = ovf_now;
      prop_rec.run_last        = !eop;

      end_rec.record_kind     = REC_END;
      end_rec.key_offset      = '0;
      end_rec.key_length      = '0;
      end_rec.value_offset    = '0;
      end_rec.value_length    = '0;
      end_rec.value_kind      = VT_STRING;
      end_rec.property_index  = '0;
      end_rec.property_count  = 6'(found_after);
      end_rec.packet_overflow = ovf_now;
      end_rec.run_last        = 1'b1;

      // queue order: property first, end record behind it
      push0      = proc && (emit || eop);
      push1      = proc && emit && eop;
      push_word0 = emit ? prop_rec : end_rec;
      push_word1 = end_rec;

      // next packet state
      if (proc && eop) begin
         phase_in       = PH_LEAD;
         pos_in         = '0;
         key_begin_in   = '0;
         key_size_in    = '0;
         value_begin_in = '0;
         dot_in         = 1'b0;
         first_char_in  = '0;
         found_in       = '0;
         overflow_in    = 1'b0;
      end else if (proc) begin
         phase_in       = ph;
         pos_in         = nxt;
         key_begin_in   = kb;
         key_size_in    = ks;
         value_begin_in = vb;
         dot_in         = dot;
         first_char_in  = fc;
         found_in       = found_after;
         overflow_in    = ovf_now;
      end else begin
         phase_in       = phase_ff;
         pos_in         = pos_ff;
         key_begin_in   = key_begin_ff;
         key_size_in    = key_size_ff;
         value_begin_in = value_begin_ff;
         dot_in         = dot_ff;
         first_char_in  = first_char_ff;
         found_in       = found_ff;
         overflow_in    = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_LEAD;
         pos_ff         <= '0;
         key_begin_ff   <= '0;
         key_size_ff    <= '0;
         value_begin_ff <= '0;
         dot_ff         <= 1'b0;
         first_char_ff  <= '0;
         found_ff       <= '0;
         overflow_ff    <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         key_begin_ff   <= key_begin_in;
         key_size_ff    <= key_size_in;
         value_begin_ff <= value_begin_in;
         dot_ff         <= dot_in;
         first_char_ff  <= first_char_in;
         found_ff       <= found_in;
         overflow_ff    <= overflow_in;
      end
   end

   // ---------------------------------------------------------------------
   // result queue
   // ---------------------------------------------------------------------
   assign rsp_take = rsp_valid && !rsp_stall;

   fjpt_fifo #(
      .DEPTH (QDEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .push1      (push1),
      .push_word0 (push_word0),
      .push_word1 (push_word1),
      .pop        (rsp_take),
      .out_valid  (rsp_valid),
      .out_word   (rsp_word),
      .room2      (q_room2)
   );

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   // byte position never runs past the saturation point
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position beyond saturation");

   // the end-of-packet word leaves the parser back at the start
   assert property (@(posedge clock) disable iff (reset)
      proc && in_word_ff.end_of_packet |=> phase_ff == PH_LEAD && pos_ff == '0
         && found_ff == '0 && !overflow_ff)
      else $error("packet state not cleared after end word");

   // once parsing has stopped no property record comes out
   assert property (@(posedge clock) disable iff (reset)
      proc && phase_ff == PH_DONE |-> !push1
         && (!push0 || push_word0.record_kind == REC_END))
      else $error("property record after parsing stopped");

   // a held input byte is never processed without queue room
   assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !q_room2 |=> in_vld_ff && $stable(in_word_ff))
      else $error("input byte lost while queue full");

endmodule

[tb/flat_json_property_tokenizer_core_tb.sv]
// ----------------------------------------------------------------------------
// flat_json_property_tokenizer_core_tb: self-checking bench for the tokenizer
// drives packet bytes through the request channel with random gaps, predicts
// the property and end records per byte, checks every response word in order
// ----------------------------------------------------------------------------
module flat_json_property_tokenizer_core_tb;
   import fjpt_pkg::*;

   localparam logic [10:0] MAX_BYTES     = 11'd1024;
   localparam logic [5:0]  MAX_PROPS     = 6'd32;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          STUCK_LIMIT   = 200;
   localparam int          PHASE_ITEMS   = 16;

   // one byte waiting to be sent; drain holds it back until no record is owed
   typedef struct packed {
      req_type word;
      logic    drain;
   } stim_item;

   logic       clock            = 1'b0;
   logic       reset            = 1'b1;
   logic       req_valid        = 1'b0;
   logic       req_stall;
   req_type    req_word         = '0;
   logic       rsp_valid;
   logic       rsp_stall        = 1'b0;
   rsp_type    rsp_word;
   logic       csr_write_enable = 1'b0;
   logic [5:0] csr_write_data   = 6'd0;

   flat_json_property_tokenizer_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_word         (req_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word         (rsp_word),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // stimulus and expectation stores
   stim_item   byte_queue[$];
   rsp_type    expected_records[$];
   logic [7:0] pkt_bytes[$];
   int         stim_count     = 0;
   int         mismatch_count = 0;
   int         cycle_count    = 0;
   int         idle_cycles    = 0;

   // handshake results of the last rising edge, read by the falling-edge drivers
   logic req_taken = 1'b0;
   logic rsp_taken = 1'b0;

   // pacing of both sides
   int src_wait    = 0;
   int sink_wait   = 0;
   bit src_steady  = 1'b0;
   bit sink_steady = 1'b0;

   // predicted tokenizer state
   logic [5:0]  tok_limit;
   phase_type   tok_phase;
   logic [10:0] tok_pos;
   logic [9:0]  tok_kbeg;
   logic [10:0] tok_ksize;
   logic [10:0] tok_vbeg;
   logic        tok_dot;
   logic [7:0]  tok_first;
   logic [5:0]  tok_found;
   logic        tok_ovf;

   task automatic report_mismatch(input string msg);
      $display("cycle %0d: mismatch, %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic clear_packet_state();
      tok_phase = PH_LEAD;
      tok_pos   = '0;
      tok_kbeg  = '0;
      tok_ksize = '0;
      tok_vbeg  = '0;
      tok_dot   = 1'b0;
      tok_first = '0;
      tok_found = '0;
      tok_ovf   = 1'b0;
   endtask

   // property record for the value that ends at end_pos
   task automatic push_property(input logic [10:0] end_pos, input logic bare);
      rsp_type     r;
      logic [10:0] len;
      len = (end_pos >= tok_vbeg) ? end_pos - tok_vbeg : 11'd0;
      r = '0;
      r.record_kind  = REC_PROPERTY;
      r.key_offset   = tok_kbeg;
      r.key_length   = tok_ksize;
      r.value_offset = tok_vbeg;
      r.value_length = len;
      if (!bare)
         r.value_kind = VT_STRING;
      else if (len == 11'd1 && (tok_first == CH_ZERO || tok_first == CH_ONE))
         r.value_kind = VT_BOOLEAN;
      else
         r.value_kind = tok_dot ? VT_DOUBLE : VT_INTEGER;
      r.property_index  = tok_found[4:0];
      r.packet_overflow = tok_ovf;
      expected_records.push_back(r);
      tok_found++;
   endtask

   // walks one byte through the phase chain and queues the records it causes
   task automatic tokenize_byte(input req_type w);
      logic [7:0]  ch;
      logic [10:0] cur;
      logic [10:0] nxt;
      logic [5:0]  lim;
      logic        again;
      int          owed_before;
      rsp_type     r;
      ch          = w.data_byte;
      cur         = tok_pos;
      owed_before = expected_records.size();
      // positions stick at the size limit once the packet is too long
      if (cur >= MAX_BYTES) begin
         cur     = MAX_BYTES;
         tok_ovf = 1'b1;
      end
      nxt   = (cur < MAX_BYTES) ? cur + 11'd1 : MAX_BYTES;
      lim   = (tok_limit > MAX_PROPS) ? MAX_PROPS : tok_limit;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         case (tok_phase)
            PH_LEAD: begin
               if (ch != CH_SPACE && ch != CH_LBRACE) begin
                  tok_phase = PH_TOP;
                  again     = 1'b1;
               end
            end
            PH_TOP: begin
               if (ch == CH_RBRACE || tok_found >= lim) begin
                  tok_phase = PH_DONE;
               end else begin
                  tok_phase = PH_KEYSKIP;
                  again     = 1'b1;
               end
            end
            PH_KEYSKIP: begin
               if (ch != CH_SPACE && ch != CH_QUOTE) begin
                  tok_kbeg  = (cur < MAX_BYTES) ? cur[9:0] : 10'(MAX_BYTES - 11'd1);
                  tok_phase = PH_KEY;
               end
            end
            PH_KEY: begin
               if (ch == CH_QUOTE) begin
                  tok_ksize = cur - {1'b0, tok_kbeg};
                  tok_phase = PH_COLON;
               end
            end
            PH_COLON: begin
               if (ch == CH_COLON) tok_phase = PH_VALSKIP;
            end
            PH_VALSKIP: begin
               if (ch == CH_QUOTE) begin
                  tok_vbeg  = nxt;
                  tok_phase = PH_STRVAL;
               end else if (ch != CH_SPACE) begin
                  tok_vbeg  = cur;
                  tok_dot   = 1'b0;
                  tok_first = ch;
                  tok_phase = PH_BAREVAL;
                  again     = 1'b1;
               end
            end
            PH_STRVAL: begin
               if (ch == CH_QUOTE) begin
                  push_property(cur, 1'b0);
                  tok_phase = PH_SEP;
               end
            end
            PH_BAREVAL: begin
               if (ch == CH_COMMA || ch == CH_RBRACE) begin
                  push_property(cur, 1'b1);
                  tok_phase = PH_SEP;
                  again     = 1'b1;
               end else if (ch == CH_DOT) begin
                  tok_dot = 1'b1;
               end
            end
            PH_SEP: begin
               if (ch != CH_COMMA && ch != CH_SPACE) begin
                  tok_phase = PH_TOP;
                  again     = 1'b1;
               end
            end
            default: tok_phase = PH_DONE;
         endcase
      end
      tok_pos = nxt;
      if (w.end_of_packet) begin
         // an open value runs to the end of the packet, an open key is dropped
         if (tok_phase == PH_STRVAL)
            push_property(nxt, 1'b0);
         else if (tok_phase == PH_BAREVAL)
            push_property(nxt, 1'b1);
         r = '0;
         r.record_kind     = REC_END;
         r.property_count  = tok_found;
         r.packet_overflow = tok_ovf;
         expected_records.push_back(r);
         clear_packet_state();
      end
      if (expected_records.size() > owed_before) begin
         r = expected_records.pop_back();
         r.run_last = 1'b1;
         expected_records.push_back(r);
      end
   endtask

   function automatic int idle_draw(input bit steady);
      return steady ? 0 : $urandom_range(0, 3);
   endfunction

   // text of a key or string value, any byte but a quote
   function automatic logic [7:0] text_char();
      logic [7:0] c;
      if ($urandom_range(0, 7) == 0) begin
         c = 8'($urandom_range(0, 255));
         if (c == CH_QUOTE) c = "_";
      end else begin
         c = 8'($urandom_range(8'h61, 8'h7A));
      end
      return c;
   endfunction

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) pkt_bytes.push_back(s[i]);
   endtask

   task automatic add_spaces(input int most);
      repeat ($urandom_range(0, most)) pkt_bytes.push_back(CH_SPACE);
   endtask

   task automatic add_digits(input int most);
      repeat ($urandom_range(1, most)) pkt_bytes.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
   endtask

   // moves the built packet into the send queue, end flag on its last byte
   task automatic flush_packet(input bit drain);
      stim_item it;
      foreach (pkt_bytes[i]) begin
         it.word.data_byte     = pkt_bytes[i];
         it.word.end_of_packet = (i == pkt_bytes.size() - 1);
         it.drain              = drain && (i == 0);
         byte_queue.push_back(it);
      end
      stim_count += pkt_bytes.size();
      pkt_bytes.delete();
   endtask

   // mostly well-formed objects, some cut short, some plain noise
   task automatic queue_packet();
      int         props;
      int         shape;
      int         cut;
      logic [7:0] c;
      logic [7:0] drop;
      props = ($urandom_range(0, 24) == 0) ? 34 : $urandom_range(0, 5);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         repeat ($urandom_range(1, 12)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         add_spaces(2);
         if ($urandom_range(0, 3) != 0) pkt_bytes.push_back(CH_LBRACE);
         for (int p = 0; p < props; p++) begin
            if (p != 0) pkt_bytes.push_back(CH_COMMA);
            add_spaces(1);
            pkt_bytes.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 5)) pkt_bytes.push_back(text_char());
            pkt_bytes.push_back(CH_QUOTE);
            add_spaces(1);
            pkt_bytes.push_back(CH_COLON);
            add_spaces(2);
            if ($urandom_range(0, 2) == 0) begin
               pkt_bytes.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 6)) pkt_bytes.push_back(text_char());
               pkt_bytes.push_back(CH_QUOTE);
            end else begin
               case ($urandom_range(0, 5))
                  0: pkt_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
                  1: ;  // empty bare value
                  2: begin
                     if ($urandom_range(0, 3) == 0) pkt_bytes.push_back("-");
                     add_digits(5);
                  end
                  3: begin
                     add_digits(3);
                     pkt_bytes.push_back(CH_DOT);
                     add_digits(3);
                  end
                  4: begin
                     // starts like a boolean but runs longer
                     pkt_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
                     add_digits(2);
                  end
                  default: begin
                     repeat ($urandom_range(1, 4)) begin
                        c = 8'($urandom_range(0, 255));
                        if (c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE ||
                            c == CH_QUOTE)
                           c = CH_DOT;
                        pkt_bytes.push_back(c);
                     end
                  end
               endcase
            end
         end
         add_spaces(1);
         pkt_bytes.push_back(CH_RBRACE);
         // junk after the closing brace is ignored by the block
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
         if (shape == 1) begin
            cut = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > cut) drop = pkt_bytes.pop_back();
         end
      end
      flush_packet($urandom_range(0, 9) == 0);
   endtask

   // long string value pushes the next property past the size limit
   task automatic queue_oversized(input int pad, input bit end_in_value);
      add_text("{\"k\":\"");
      repeat (pad) pkt_bytes.push_back(text_char());
      add_text("\", \"p\":12.5");
      if (!end_in_value) add_text(", \"q\":\"zz\"}");
      flush_packet(1'b0);
   endtask

   // returns on a falling edge once nothing is queued, in flight or owed
   task automatic wait_idle();
      @(negedge clock);
      while (byte_queue.size() != 0 || req_valid || expected_records.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // request driver: new word at the falling edge once the last one went in
   always @(negedge clock) begin : byte_driver
      stim_item next_item;
      if (reset) begin
         req_valid <= 1'b0;
         src_wait = 0;
      end else if (!req_valid || req_taken) begin
         // a word just went in, draw the gap before the next one
         if (req_valid) src_wait = idle_draw(src_steady);
         if (src_wait > 0) begin
            src_wait--;
            req_valid <= 1'b0;
         end else if (byte_queue.size() != 0 &&
                      (!byte_queue[0].drain || expected_records.size() == 0)) begin
            next_item = byte_queue.pop_front();
            req_valid <= 1'b1;
            req_word  <= next_item.word;
            if ($urandom_range(0, 47) == 0) src_steady = !src_steady;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: a stall of random length drawn after each word taken
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_taken) begin
            sink_wait = idle_draw(sink_steady);
            if ($urandom_range(0, 47) == 0) sink_steady = !sink_steady;
         end
         if (sink_wait > 0) begin
            sink_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // monitor: handshakes sampled at the rising edge, check then predict
   always @(posedge clock) begin : record_monitor
      rsp_type want;
      if (reset) begin
         req_taken   = 1'b0;
         rsp_taken   = 1'b0;
         idle_cycles = 0;
         tok_limit   = LIMIT_RESET;
         clear_packet_state();
      end else begin
         cycle_count++;
         req_taken = req_valid && !req_stall;
         rsp_taken = rsp_valid && !rsp_stall;
         if (rsp_taken) begin
            if (expected_records.size() == 0) begin
               report_mismatch($sformatf("word with nothing expected: %h", rsp_word));
            end else begin
               want = expected_records.pop_front();
               if (rsp_word !== want)
                  report_mismatch($sformatf("got %h expected %h", rsp_word, want));
            end
         end
         // limit register only moves while the block is idle
         if (csr_write_enable) tok_limit = csr_write_data;
         if (req_taken) tokenize_byte(req_word);
         // watchdog on cycles with no handshake at all
         if (req_taken || rsp_taken)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STUCK_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      logic [5:0] limit_plan [9];
      int         phase_start;
      limit_plan = '{6'd1, 6'd3, 6'd63, 6'd0, 6'd32, 6'd0, 6'd0, 6'd0, 6'd2};
      for (int i = 5; i < 8; i++) limit_plan[i] = 6'($urandom_range(4, 31));

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // directed packets under the reset limit
      add_text("{\"a\":\"\",\"b\":.5}");   // empty string, double closed by brace
      flush_packet(1'b0);
      add_text("\"b\":}");                  // empty bare value, no leading brace
      flush_packet(1'b0);
      add_text(" \"c\":1");                 // packet ends inside a value
      flush_packet(1'b0);
      add_text("{\"d\":");                  // packet ends before the value
      flush_packet(1'b0);
      pkt_bytes.push_back(8'h00);           // packet ends inside the key
      pkt_bytes.push_back(8'hFF);
      flush_packet(1'b1);

      // random phases, each under its own property limit
      foreach (limit_plan[p]) begin
         wait_idle();
         csr_write_enable <= 1'b1;
         csr_write_data   <= limit_plan[p];
         @(negedge clock);
         csr_write_enable <= 1'b0;
         // key and value offsets saturate, packet ends inside the value
         if (limit_plan[p] == MAX_PROPS) queue_oversized(1016, 1'b1);
         phase_start = stim_count;
         while (stim_count - phase_start < PHASE_ITEMS) queue_packet();
      end

      wait_idle();
      if (expected_records.size() != 0) report_mismatch("records never arrived");
      if (mismatch_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

[filelist.f]
hdl/fjpt_pkg.sv
hdl/fjpt_fifo.sv
hdl/flat_json_property_tokenizer_core.sv
tb/flat_json_property_tokenizer_core_tb.sv
